### rtl/core/xsr128pp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsr128pp_pkg
// Shared types and constants of the xoshiro128++ generator with splitmix64
// seed expansion.
// ----------------------------------------------------------------------------
package xsr128pp_pkg;

  localparam logic [63:0] DEFAULT_SEED = 64'd88172645463325252;
  localparam logic [63:0] GOLDEN_STEP  = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned SEED_W = 64;

  localparam logic CMD_GENERATE = 1'b0;
  localparam logic CMD_RESEED   = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_DEFAULT,
    OP_LOAD_SEED,
    OP_ADVANCE,
    OP_MUL_LL,
    OP_MUL_HL,
    OP_MUL_LH,
    OP_REMIX,
    OP_STORE,
    OP_GENERATE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   sel_b;
  } dp_cmd_t;

  typedef struct packed {
    logic last_word;
  } dp_status_t;

endpackage

### rtl/core/xsr128pp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsr128pp_dp
// Generator datapath: four state words, the splitmix64 cursor and mix
// registers, one shared 32x32 multiplier and the output word register.
// ----------------------------------------------------------------------------
module xsr128pp_dp (
  input  logic                                   clk,
  input  xsr128pp_pkg::dp_cmd_t                  cmd,
  input  logic [xsr128pp_pkg::SEED_W-1:0]        seed,
  output xsr128pp_pkg::dp_status_t               status,
  output logic [xsr128pp_pkg::WORD_W-1:0]        random_word
);

  logic [3:0][31:0] words;
  logic [63:0]      cursor;
  logic [63:0]      mval;
  logic [63:0]      acc;
  logic [1:0]       wcnt;

  logic [63:0] step_sum;
  logic [63:0] mul_c;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [31:0] sum03;
  logic [31:0] gen_word;
  logic [31:0] n0, n1, n2, n3, t2, t3;

  assign step_sum = cursor + xsr128pp_pkg::GOLDEN_STEP;
  assign mul_c    = cmd.sel_b ? xsr128pp_pkg::MIX_MUL_B : xsr128pp_pkg::MIX_MUL_A;

  always_comb begin
    case (cmd.op)
      xsr128pp_pkg::OP_MUL_HL: begin
        mul_a = mval[63:32];
        mul_b = mul_c[31:0];
      end
      xsr128pp_pkg::OP_MUL_LH: begin
        mul_a = mval[31:0];
        mul_b = mul_c[63:32];
      end
      default: begin
        mul_a = mval[31:0];
        mul_b = mul_c[31:0];
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  // xoshiro128++ output and state update
  assign sum03    = words[0] + words[3];
  assign gen_word = {sum03[24:0], sum03[31:25]} + words[0];
  assign t2       = words[2] ^ words[0];
  assign t3       = words[3] ^ words[1];
  assign n1       = words[1] ^ t2;
  assign n0       = words[0] ^ t3;
  assign n2       = t2 ^ {words[1][22:0], 9'd0};
  assign n3       = {t3[20:0], t3[31:21]};

  assign status.last_word = (wcnt == 2'd3);

  always_ff @(posedge clk) begin
    unique case (cmd.op) inside
      xsr128pp_pkg::OP_LOAD_DEFAULT: begin
        cursor <= xsr128pp_pkg::DEFAULT_SEED;
        wcnt   <= 2'd0;
      end
      xsr128pp_pkg::OP_LOAD_SEED: begin
        cursor <= seed;
        wcnt   <= 2'd0;
      end
      xsr128pp_pkg::OP_ADVANCE: begin
        cursor <= step_sum;
        mval   <= step_sum ^ (step_sum >> 30);
      end
      xsr128pp_pkg::OP_MUL_LL: begin
        acc <= prod;
      end
      xsr128pp_pkg::OP_MUL_HL, xsr128pp_pkg::OP_MUL_LH: begin
        acc[63:32] <= acc[63:32] + prod[31:0];
      end
      xsr128pp_pkg::OP_REMIX: begin
        mval <= acc ^ (acc >> 27);
      end
      xsr128pp_pkg::OP_STORE: begin
        words[wcnt] <= acc[31:0] ^ acc[62:31];
        wcnt        <= wcnt + 2'd1;
      end
      xsr128pp_pkg::OP_GENERATE: begin
        words       <= {n3, n2, n1, n0};
        random_word <= gen_word;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/xsr128pp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsr128pp_ctrl
// Sequencer: input and output handshakes, seeding sequence, datapath commands.
// ----------------------------------------------------------------------------
module xsr128pp_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic                        s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output xsr128pp_pkg::dp_cmd_t       cmd,
  input  xsr128pp_pkg::dp_status_t    status
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_INIT  = 11'b000_0000_0010,
    S_STEP  = 11'b000_0000_0100,
    S_MA0   = 11'b000_0000_1000,
    S_MA1   = 11'b000_0001_0000,
    S_MA2   = 11'b000_0010_0000,
    S_REMIX = 11'b000_0100_0000,
    S_MB0   = 11'b000_1000_0000,
    S_MB1   = 11'b001_0000_0000,
    S_MB2   = 11'b010_0000_0000,
    S_STORE = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd.op     = xsr128pp_pkg::OP_NONE;
    cmd.sel_b  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (s_tuser == xsr128pp_pkg::CMD_RESEED) begin
            cmd.op     = xsr128pp_pkg::OP_LOAD_SEED;
            state_next = S_STEP;
          end else begin
            cmd.op = xsr128pp_pkg::OP_GENERATE;
          end
        end
      end
      S_INIT: begin
        cmd.op     = xsr128pp_pkg::OP_LOAD_DEFAULT;
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.op     = xsr128pp_pkg::OP_ADVANCE;
        state_next = S_MA0;
      end
      S_MA0: begin
        cmd.op     = xsr128pp_pkg::OP_MUL_LL;
        state_next = S_MA1;
      end
      S_MA1: begin
        cmd.op     = xsr128pp_pkg::OP_MUL_HL;
        state_next = S_MA2;
      end
      S_MA2: begin
        cmd.op     = xsr128pp_pkg::OP_MUL_LH;
        state_next = S_REMIX;
      end
      S_REMIX: begin
        cmd.op     = xsr128pp_pkg::OP_REMIX;
        state_next = S_MB0;
      end
      S_MB0: begin
        cmd.op     = xsr128pp_pkg::OP_MUL_LL;
        cmd.sel_b  = 1'b1;
        state_next = S_MB1;
      end
      S_MB1: begin
        cmd.op     = xsr128pp_pkg::OP_MUL_HL;
        cmd.sel_b  = 1'b1;
        state_next = S_MB2;
      end
      S_MB2: begin
        cmd.op     = xsr128pp_pkg::OP_MUL_LH;
        cmd.sel_b  = 1'b1;
        state_next = S_STORE;
      end
      S_STORE: begin
        cmd.op     = xsr128pp_pkg::OP_STORE;
        state_next = status.last_word ? S_IDLE : S_STEP;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (s_tuser == xsr128pp_pkg::CMD_GENERATE)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/xoshiro128pp_prng_with_seeding_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xoshiro128pp_prng_with_seeding_core
// xoshiro128++ 32-bit random word generator with splitmix64 seed expansion.
//
// channel   dir  word contents
// s_*       in   tuser: command (0 generate, 1 reseed); tdata: seed
// m_*       out  tdata: random_word
//
// A generate word is taken back to back while the output register is free
// or being drained. A reseed word runs four splitmix64 rounds: S_STEP,
// a 64-bit mul, S_REMIX, a second 64-bit mul and S_STORE, on the shared
// 32x32 multiplier (three partial products per 64-bit mul). After rst the
// default seed is expanded the same way before s_tready rises.
// A stalled output holds its word and stops new input.
// ----------------------------------------------------------------------------
module xoshiro128pp_prng_with_seeding_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] seed
  input  logic        s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [31:0] random_word
);

  xsr128pp_pkg::dp_cmd_t    cmd;
  xsr128pp_pkg::dp_status_t status;

  xsr128pp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  xsr128pp_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .seed        (s_tdata),
    .status      (status),
    .random_word (m_tdata)
  );

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output word stalled");

  a_generate_gives_word: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == xsr128pp_pkg::CMD_GENERATE)) |=> m_tvalid)
    else $error("generate did not present a word");

  a_reseed_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == xsr128pp_pkg::CMD_RESEED)) |=> !s_tready)
    else $error("input ready during seed expansion");

endmodule
